// File: design/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// shared types and token kind codes for the character class tokenizer
// ----------------------------------------------------------------------------
package cct_pkg;

  typedef logic [3:0] kind_t;

  localparam kind_t KIND_LPAREN  = 4'd0;
  localparam kind_t KIND_RPAREN  = 4'd1;
  localparam kind_t KIND_LBRACK  = 4'd2;
  localparam kind_t KIND_RBRACK  = 4'd3;
  localparam kind_t KIND_LBRACE  = 4'd4;
  localparam kind_t KIND_RBRACE  = 4'd5;
  localparam kind_t KIND_COMMA   = 4'd6;
  localparam kind_t KIND_DIGIT   = 4'd7;
  localparam kind_t KIND_SMALL   = 4'd8;
  localparam kind_t KIND_CAPITAL = 4'd9;
  localparam kind_t KIND_SYMBOL  = 4'd10;
  localparam kind_t KIND_NONE    = 4'd15;

  localparam logic [7:0] CH_END        = 8'h00;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

  typedef struct packed {
    logic [7:0] tok_char;
    kind_t      tok_kind;
    logic       tok_first;
    logic       tok_final;
    logic       last;
  } result_t;

  typedef struct packed {
    kind_t      run_kind;
    logic [7:0] held_char;
    logic       held_first;
  } run_state_t;

  typedef struct packed {
    result_t    res_a;
    result_t    res_b;
    logic [1:0] count;
    run_state_t nxt;
  } step_t;

endpackage

// File: design/cct_classify.sv
// ----------------------------------------------------------------------------
// cct_classify
// classifies one byte against the open run and forms up to two result items
// ----------------------------------------------------------------------------
module cct_classify import cct_pkg::*; (
  input  logic [7:0] ch,
  input  run_state_t cur,
  output step_t      step
);

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return c inside {["a":"z"]};
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return c inside {["A":"Z"]};
  endfunction

  function automatic logic is_sym(input logic [7:0] c);
    return c inside {"!", "$", "%", "&", "-", "=", "~", "^", "|", "@", "+", ":",
                     "*", "<", ">", "/", "?", "."};
  endfunction

  function automatic kind_t delim_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "[":     k = KIND_LBRACK;
      "]":     k = KIND_RBRACK;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ",":     k = KIND_COMMA;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t start_kind(input logic [7:0] c);
    kind_t k;
    if (is_digit(c)) k = KIND_DIGIT;
    else if (is_lower(c)) k = KIND_SMALL;
    else if (is_upper(c)) k = KIND_CAPITAL;
    else if (is_sym(c)) k = KIND_SYMBOL;
    else k = KIND_NONE;
    return k;
  endfunction

  function automatic logic continues(input kind_t k, input logic [7:0] c);
    logic r;
    case (k)
      KIND_DIGIT:   r = is_digit(c);
      KIND_SMALL:   r = is_lower(c) || is_digit(c) || (c == CH_UNDERSCORE);
      KIND_CAPITAL: r = is_upper(c) || is_lower(c) || is_digit(c);
      KIND_SYMBOL:  r = is_sym(c);
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  logic    open_run;
  logic    cont;
  logic    ch_live;
  kind_t   dk;
  kind_t   sk;
  logic    delim_hit;
  result_t held_res;
  result_t delim_res;

  always_comb begin
    open_run  = (cur.run_kind != KIND_NONE);
    ch_live   = (ch != CH_END);
    cont      = open_run && ch_live && continues(cur.run_kind, ch);
    dk        = delim_kind(ch);
    sk        = start_kind(ch);
    delim_hit = !cont && ch_live && (dk != KIND_NONE);

    held_res  = '{tok_char: cur.held_char, tok_kind: cur.run_kind,
                  tok_first: cur.held_first, tok_final: !cont, last: 1'b1};
    delim_res = '{tok_char: ch, tok_kind: dk, tok_first: 1'b1,
                  tok_final: 1'b1, last: 1'b1};

    step.count = {1'b0, open_run} + {1'b0, delim_hit};
    step.res_b = delim_res;
    if (open_run) begin
      step.res_a      = held_res;
      step.res_a.last = !delim_hit;
    end else begin
      step.res_a = delim_res;
    end

    // next run state
    if (cont) begin
      step.nxt = '{run_kind: cur.run_kind, held_char: ch, held_first: 1'b0};
    end else if (ch_live && !delim_hit && (sk != KIND_NONE)) begin
      step.nxt = '{run_kind: sk, held_char: ch, held_first: 1'b1};
    end else begin
      step.nxt = '{run_kind: KIND_NONE, held_char: 8'h00, held_first: 1'b0};
    end
  end

endmodule

// File: design/char_class_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// char_class_tokenizer_unit
// longest-match character class tokenizer, one byte in, token characters out
// ----------------------------------------------------------------------------
// channel  dir  payload
// s_axis   in   tdata[7:0] ch
// m_axis   out  tdata tok_char, tok_kind, tok_first, tok_final; tlast last
//
// one byte is taken per cycle while the four-entry result queue has room for
// two items; a byte yields zero, one or two result items, and the output port
// drains one item per cycle while m_axis_tready is high, so bytes giving two
// results throttle the input. results are queued the cycle after their byte.
// rst is synchronous and clears the run state and the queue.
// ----------------------------------------------------------------------------
module char_class_tokenizer_unit import cct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // tok_char, tok_kind, tok_first, tok_final, zeros
  output logic        m_axis_tlast    // last
);

  run_state_t run_st;
  step_t      step;
  result_t    queue [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic [1:0] push_n;
  logic       accept;
  logic       pop;
  result_t    head;

  cct_classify u_classify (
    .ch   (s_axis_tdata),
    .cur  (run_st),
    .step (step)
  );

  assign s_axis_tready = (count <= 3'd2);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (count != 3'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign push_n        = accept ? step.count : 2'd0;
  assign count_next    = count + {1'b0, push_n} - {2'b00, pop};

  assign head          = queue[rd_ptr];
  assign m_axis_tdata  = {2'b00, head.tok_final, head.tok_first, head.tok_kind,
                          head.tok_char};
  assign m_axis_tlast  = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_st <= '{run_kind: KIND_NONE, held_char: 8'h00, held_first: 1'b0};
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (accept) begin
        run_st <= step.nxt;
      end
      wr_ptr <= wr_ptr + push_n;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= step.res_a;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + 2'd1] <= step.res_b;
    end
  end

`ifndef SYNTHESIS
  a_level_bound : assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue overflow");

  a_open_run_emits : assert property (@(posedge clk) disable iff (rst)
    accept && (run_st.run_kind != KIND_NONE) |=> m_axis_tvalid)
    else $error("held character not queued");

  a_first_needs_run : assert property (@(posedge clk) disable iff (rst)
    (run_st.run_kind == KIND_NONE) |-> !run_st.held_first)
    else $error("held first flag without open run");
`endif

endmodule
